// File: design/tppt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tppt_pkg
// Shared types and codes for the two-phase pulse train timer.
// ----------------------------------------------------------------------------
package tppt_pkg;

    // Command codes carried in the op field of an item
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_PHASE  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SECOND_PHASE = 1'b1;

    // Event levels
    localparam logic LEVEL_LOW  = 1'b0;
    localparam logic LEVEL_HIGH = 1'b1;

    typedef struct packed {
        logic        level;
        logic [31:0] stamp;
        logic        last;
    } evt_t;

    // Up to two events produced by one item, in order
    typedef struct packed {
        logic [1:0] cnt;
        evt_t       ev0;
        evt_t       ev1;
    } push_t;

endpackage

// File: design/tppt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tppt_item_if / tppt_event_if
// Valid/ready channels for command items and timer events.
// ----------------------------------------------------------------------------
interface tppt_item_if #(
    parameter int COUNT_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            op;
    logic [31:0]           tick_time;
    logic [COUNT_BITS-1:0] repeat_count;
    logic                  run_forever;

    modport source (output valid, op, tick_time, repeat_count, run_forever, input ready);
    modport sink   (input valid, op, tick_time, repeat_count, run_forever, output ready);
endinterface

interface tppt_event_if;
    logic        valid;
    logic        ready;
    logic        event_level;
    logic [31:0] event_time;
    logic        last_event;

    modport source (output valid, event_level, event_time, last_event, input ready);
    modport sink   (input valid, event_level, event_time, last_event, output ready);
endinterface

// File: design/two_phase_pulse_train_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_phase_pulse_train_timer
// Tick-driven two-phase pulse train timer with a valid/ready command channel
// and a valid/ready event channel.
// ----------------------------------------------------------------------------
// Items enter an input register; from there one pass of compare,
// reload and decrement logic updates the timer state and drops zero, one or
// two events into a two-entry output queue. One item is taken per cycle as
// long as the queue has room for the events of the item in the input
// register; an item that yields two events, or a stalled event consumer,
// holds the input register until the queue drains, so the event port (one
// event per cycle) sets the sustained rate. Configuration writes take effect
// at once and are meant for idle periods only.
// ----------------------------------------------------------------------------
module two_phase_pulse_train_timer #(
    parameter int PERIOD_BITS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tppt_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [PERIOD_BITS-1:0]            cfg_data,
    tppt_item_if.sink                         items,
    tppt_event_if.source                      events
);

    // Input register stage
    logic                  s1_valid_reg;
    logic [1:0]            s1_op_reg;
    logic [31:0]           s1_time_reg;
    logic [COUNT_BITS-1:0] s1_count_reg;
    logic                  s1_forever_reg;

    tppt_pkg::push_t push;
    tppt_pkg::evt_t  head;
    logic [1:0]      q_cnt;
    logic [2:0]      q_fill;
    logic            advance;
    logic            take;
    logic            pop;

    // Advance the staged item only when its events fit without counting on
    // this cycle's pop; keeps the input side free of the output ready.
    assign q_fill  = {1'b0, q_cnt} + {1'b0, push.cnt};
    assign advance = s1_valid_reg && (q_fill <= 3'd2);
    assign items.ready = !s1_valid_reg || advance;
    assign take    = items.valid && items.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (items.ready)
            s1_valid_reg <= items.valid;
    end

    // Hold payload until the next transfer
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_op_reg      <= items.op;
            s1_time_reg    <= items.tick_time;
            s1_count_reg   <= items.repeat_count;
            s1_forever_reg <= items.run_forever;
        end
    end

    tppt_core #(
        .PERIOD_BITS (PERIOD_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fire         (advance),
        .op           (s1_op_reg),
        .tick_time    (s1_time_reg),
        .repeat_count (s1_count_reg),
        .run_forever  (s1_forever_reg),
        .push         (push)
    );

    // Drop the head event on each output transfer
    assign pop = events.valid && events.ready;

    tppt_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_en (advance),
        .push    (push),
        .pop     (pop),
        .cnt     (q_cnt),
        .head    (head)
    );

    assign events.valid       = (q_cnt != 2'd0);
    assign events.event_level = head.level;
    assign events.event_time  = head.stamp;
    assign events.last_event  = head.last;

endmodule

// File: design/tppt_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tppt_core
// Timer state, phase registers and the per-item event/next-state logic.
// ----------------------------------------------------------------------------
module tppt_core #(
    parameter int PERIOD_BITS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tppt_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [PERIOD_BITS-1:0]            cfg_data,
    input  logic                              fire,
    input  logic [1:0]                        op,
    input  logic [31:0]                       tick_time,
    input  logic [COUNT_BITS-1:0]             repeat_count,
    input  logic                              run_forever,
    output tppt_pkg::push_t                   push
);

    localparam int DCW = PERIOD_BITS + 2;

    logic [PERIOD_BITS-1:0] first_reg, second_reg;
    logic                   armed_reg, armed_next;
    logic [COUNT_BITS-1:0]  cycles_reg, cycles_next;
    logic                   forever_reg, forever_next;
    logic signed [DCW-1:0]  dc_reg, dc_next, dc_base;
    logic                   phase1_reg, phase1_next;
    logic                   pend_reg, pend_next;
    logic                   expire;
    logic                   active;
    logic                   phase_level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= '0;
            second_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tppt_pkg::CFG_FIRST_PHASE:  first_reg  <= cfg_data;
                tppt_pkg::CFG_SECOND_PHASE: second_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign expire      = dc_reg[DCW-1] || (dc_reg == '0);
    assign phase_level = phase1_reg ? tppt_pkg::LEVEL_HIGH : tppt_pkg::LEVEL_LOW;

    always_comb
    begin
        armed_next   = armed_reg;
        cycles_next  = cycles_reg;
        forever_next = forever_reg;
        dc_next      = dc_reg;
        phase1_next  = phase1_reg;
        pend_next    = pend_reg;
        dc_base      = dc_reg;
        active       = 1'b0;
        push         = '0;

        case (op)
            tppt_pkg::OP_START:
            begin
                armed_next   = 1'b1;
                forever_next = run_forever;
                cycles_next  = run_forever ? '0 : repeat_count;
                dc_next      = DCW'(first_reg);
                phase1_next  = 1'b1;
                pend_next    = 1'b1;
            end
            tppt_pkg::OP_STOP:
            begin
                armed_next = 1'b0;
            end
            tppt_pkg::OP_TICK:
            begin
                if (armed_reg)
                begin
                    if (!forever_reg && cycles_reg == '0)
                        armed_next = 1'b0;
                    else
                        active = 1'b1;
                end
            end
            default: ;
        endcase

        if (active)
        begin
            pend_next = 1'b0;
            if (expire)
            begin
                phase1_next = !phase1_reg;
                if (phase1_reg)
                begin
                    dc_base = DCW'(second_reg);
                    if (!forever_reg)
                        cycles_next = cycles_reg - 1'b1;
                end
                else
                begin
                    dc_base = DCW'(first_reg);
                end
            end
            dc_next = dc_base - 1'b1;

            // Order: pending start low event first, then the phase event
            if (pend_reg && expire)
            begin
                push.cnt = 2'd2;
                push.ev0 = '{level: tppt_pkg::LEVEL_LOW, stamp: tick_time, last: 1'b0};
                push.ev1 = '{level: phase_level, stamp: tick_time, last: 1'b1};
            end
            else if (pend_reg)
            begin
                push.cnt = 2'd1;
                push.ev0 = '{level: tppt_pkg::LEVEL_LOW, stamp: tick_time, last: 1'b1};
            end
            else if (expire)
            begin
                push.cnt = 2'd1;
                push.ev0 = '{level: phase_level, stamp: tick_time, last: 1'b1};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg   <= 1'b0;
            cycles_reg  <= '0;
            forever_reg <= 1'b0;
            dc_reg      <= '0;
            phase1_reg  <= 1'b1;
            pend_reg    <= 1'b0;
        end
        else if (fire)
        begin
            armed_reg   <= armed_next;
            cycles_reg  <= cycles_next;
            forever_reg <= forever_next;
            dc_reg      <= dc_next;
            phase1_reg  <= phase1_next;
            pend_reg    <= pend_next;
        end
    end

endmodule

// File: design/tppt_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tppt_outq
// Two-entry event queue: takes up to two events at once, hands out one.
// ----------------------------------------------------------------------------
module tppt_outq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_en,
    input  tppt_pkg::push_t push,
    input  logic            pop,
    output logic [1:0]      cnt,
    output tppt_pkg::evt_t  head
);

    tppt_pkg::evt_t e0_reg, e0_next, e1_reg, e1_next, a0;
    logic [1:0]     cnt_reg, cnt_next, cnt_pop, n_in;

    assign cnt_pop = cnt_reg - {1'b0, pop};
    assign n_in    = push_en ? push.cnt : 2'd0;
    assign a0      = pop ? e1_reg : e0_reg;

    always_comb
    begin
        case (cnt_pop)
            2'd0:
            begin
                e0_next = push.ev0;
                e1_next = push.ev1;
            end
            2'd1:
            begin
                e0_next = a0;
                e1_next = push.ev0;
            end
            default:
            begin
                e0_next = e0_reg;
                e1_next = e1_reg;
            end
        endcase
        cnt_next = cnt_pop + n_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        e0_reg <= e0_next;
        e1_reg <= e1_next;
    end

    assign cnt  = cnt_reg;
    assign head = e0_reg;

endmodule

// File: design/tppt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tppt_checker
// Port-level checks on the event channel of the pulse train timer.
// ----------------------------------------------------------------------------
module tppt_checker (
    input logic          clk,
    input logic          rst_n,
    tppt_event_if.source events
);

    // A stalled event stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        events.valid && !events.ready |=> events.valid)
        else $error("event dropped while stalled");

    // A stalled event keeps its time stamp
    a_hold_time: assert property (@(posedge clk) disable iff (!rst_n)
        events.valid && !events.ready |=> $stable(events.event_time))
        else $error("event time changed while stalled");

    // Only the start low event can be followed by another from the same tick
    a_first_is_low: assert property (@(posedge clk) disable iff (!rst_n)
        events.valid && !events.last_event |-> events.event_level == 1'b0)
        else $error("non-final event is not a low event");

    // After the start low event comes the high event of the same tick
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        events.valid && events.ready && !events.last_event |=>
            events.valid && events.last_event && events.event_level == 1'b1
            && events.event_time == $past(events.event_time))
        else $error("second event of a tick missing or wrong");

endmodule

bind two_phase_pulse_train_timer tppt_checker u_tppt_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .events (events)
);

// File: test/two_phase_pulse_train_timer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_phase_pulse_train_timer_tb
// Self-checking bench for the two-phase pulse train timer. A cycle-free
// predictor tracks arming, repeat count, phase and down-counter for every
// command transfer and queues the events it expects. Each event transfer is
// checked field by field against the oldest queued event. The stimulus opens
// with hand-picked corner cases, then runs several phase-length settings with
// random command streams, random valid/ready gaps, a long consumer stall and
// a full drain before reprogramming.
// ----------------------------------------------------------------------------
module two_phase_pulse_train_timer_tb;

    localparam int PERIOD_BITS = 16;
    localparam int COUNT_BITS  = 16;

    // Op code 3 has no meaning; the timer must ignore it
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Transfer to first event passes the input register and the output queue; leave some margin
    localparam int SETTLE_CYCLES   = 6;
    // Longest honest quiet stretch is the consumer hold-off below
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int PHASE_COUNT     = 6;
    localparam int ITEMS_PER_PHASE = 170;

    // ------------------------------------------------------------------------
    // Scoreboard: timer predictor plus queue of expected events
    // ------------------------------------------------------------------------
    class pulse_train_scoreboard #(int PW = 16, int CW = 16);
        logic [PW-1:0]         first_len;
        logic [PW-1:0]         second_len;
        logic                  armed;
        logic                  forever_mode;
        logic                  in_first_phase;
        logic                  first_tick_pending;
        logic [CW-1:0]         cycles_left;
        logic signed [PW+1:0]  down_count;
        tppt_pkg::evt_t        expected_events[$];
        int                    mismatches;

        function new();
            first_len          = '0;
            second_len         = '0;
            armed              = 1'b0;
            forever_mode       = 1'b0;
            in_first_phase     = 1'b1;
            first_tick_pending = 1'b0;
            cycles_left        = '0;
            down_count         = '0;
            mismatches         = 0;
        endfunction

        function void set_phases(logic [PW-1:0] first, logic [PW-1:0] second);
            first_len  = first;
            second_len = second;
        endfunction

        function tppt_pkg::evt_t make_event(logic level, logic [31:0] stamp);
            tppt_pkg::evt_t ev;
            ev.level = level;
            ev.stamp = stamp;
            ev.last  = 1'b0;
            return ev;
        endfunction

        // Advance the timer by one accepted command and queue its events
        function void note_item(logic [1:0] op, logic [31:0] stamp,
                                logic [CW-1:0] count, logic run_forever);
            tppt_pkg::evt_t batch [0:1];
            int             n;
            n = 0;
            if (op == tppt_pkg::OP_START)
            begin
                armed              = 1'b1;
                forever_mode       = run_forever;
                cycles_left        = run_forever ? '0 : count;
                down_count         = {2'b00, first_len};
                in_first_phase     = 1'b1;
                first_tick_pending = 1'b1;
            end
            else if (op == tppt_pkg::OP_STOP)
            begin
                armed = 1'b0;
            end
            else if (op == tppt_pkg::OP_TICK && armed)
            begin
                if (!forever_mode && cycles_left == 0)
                begin
                    armed = 1'b0;
                end
                else
                begin
                    if (first_tick_pending)
                    begin
                        batch[n] = make_event(tppt_pkg::LEVEL_LOW, stamp);
                        n++;
                        first_tick_pending = 1'b0;
                    end
                    if (down_count <= 0)
                    begin
                        if (in_first_phase)
                        begin
                            batch[n] = make_event(tppt_pkg::LEVEL_HIGH, stamp);
                            n++;
                            down_count = {2'b00, second_len};
                            if (!forever_mode)
                                cycles_left = cycles_left - 1'b1;
                        end
                        else
                        begin
                            batch[n] = make_event(tppt_pkg::LEVEL_LOW, stamp);
                            n++;
                            down_count = {2'b00, first_len};
                        end
                        in_first_phase = !in_first_phase;
                    end
                    down_count = down_count - (PW+2)'(1);
                end
            end
            for (int k = 0; k < n; k++)
            begin
                if (k == n - 1)
                    batch[k].last = 1'b1;
                expected_events.push_back(batch[k]);
            end
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s", $realtime, what);
        endfunction

        function void check_event(logic level, logic [31:0] stamp, logic last);
            tppt_pkg::evt_t want;
            if (expected_events.size() == 0)
            begin
                report($sformatf("unexpected event: level %0b time %08h last %0b",
                                 level, stamp, last));
                return;
            end
            want = expected_events.pop_front();
            if (want.level !== level || want.stamp !== stamp || want.last !== last)
                report($sformatf({"event mismatch: expected level %0b time %08h last %0b,",
                                  " got level %0b time %08h last %0b"},
                                 want.level, want.stamp, want.last, level, stamp, last));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block under test
    // ------------------------------------------------------------------------
    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              cfg_we;
    logic [tppt_pkg::CFG_IDX_BITS-1:0] cfg_index;
    logic [PERIOD_BITS-1:0]            cfg_data;

    tppt_item_if #(.COUNT_BITS(COUNT_BITS)) items ();
    tppt_event_if                           events ();

    pulse_train_scoreboard #(PERIOD_BITS, COUNT_BITS) sb;

    // Percent of cycles in which each side holds back
    int send_idle_pct     = 36;
    int recv_idle_pct     = 54;
    // Consumer hold-off, counted down by the consumer process
    int stall_cycles_left = 0;
    int quiet_cycles;

    always #4 clk = ~clk;

    two_phase_pulse_train_timer #(
        .PERIOD_BITS (PERIOD_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .items     (items),
        .events    (events)
    );

    // ------------------------------------------------------------------------
    // Event consumer: random back-pressure, or a hard hold-off when requested
    // ------------------------------------------------------------------------
    initial
    begin
        events.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_cycles_left > 0)
            begin
                // Hold ready low so the block fills up and stalls its input
                stall_cycles_left--;
                events.ready <= 1'b0;
            end
            else
                events.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: sample both channels at the clock edge, before new drive lands
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // An event transfer can never belong to a command accepted at the
            // same edge, so check events before noting the command
            if (events.valid && events.ready)
                sb.check_event(events.event_level, events.event_time, events.last_event);
            if (items.valid && items.ready)
                sb.note_item(items.op, items.tick_time, items.repeat_count,
                             items.run_forever);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run after too many cycles with no transfer at all
    // ------------------------------------------------------------------------
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((items.valid && items.ready) || (events.valid && events.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Command driver tasks
    // ------------------------------------------------------------------------

    // Offer one command, with random gaps ahead of it; return on its transfer
    task automatic send_item(input logic [1:0] op, input logic [31:0] stamp,
                             input logic [COUNT_BITS-1:0] count,
                             input logic run_forever);
        while ($urandom_range(99) < send_idle_pct)
        begin
            items.valid <= 1'b0;
            @(posedge clk);
        end
        items.valid        <= 1'b1;
        items.op           <= op;
        items.tick_time    <= stamp;
        items.repeat_count <= count;
        items.run_forever  <= run_forever;
        @(posedge clk);
        while (!items.ready)
            @(posedge clk);
    endtask

    // Drop valid and wait until every predicted event has been transferred,
    // then let any command that yields no event clear the pipeline
    task automatic drain_events();
        items.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both phase lengths, first then second; call only when idle
    task automatic program_phases(input logic [PERIOD_BITS-1:0] first,
                                  input logic [PERIOD_BITS-1:0] second);
        cfg_we    <= 1'b1;
        cfg_index <= tppt_pkg::CFG_FIRST_PHASE;
        cfg_data  <= first;
        @(posedge clk);
        cfg_index <= tppt_pkg::CFG_SECOND_PHASE;
        cfg_data  <= second;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_phases(first, second);
    endtask

    // Mostly ticks on an armed timer, with restarts, stops and some noise
    task automatic send_random_item();
        int                    pick;
        logic [COUNT_BITS-1:0] count;
        pick = $urandom_range(99);
        if ($urandom_range(3) == 0)
            count = COUNT_BITS'($urandom);
        else
            count = COUNT_BITS'($urandom_range(8));
        if (pick < 6)
            send_item(tppt_pkg::OP_START, $urandom, count, $urandom_range(4) == 0);
        else if (pick < 9)
            send_item(tppt_pkg::OP_STOP, $urandom, count, $urandom_range(1));
        else if (pick < 11)
            send_item(OP_UNUSED, $urandom, count, $urandom_range(1));
        else
            send_item(tppt_pkg::OP_TICK, $urandom, count, $urandom_range(1));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [PERIOD_BITS-1:0] first_len;
        logic [PERIOD_BITS-1:0] second_len;

        sb = new();
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= tppt_pkg::CFG_FIRST_PHASE;
        cfg_data           <= '0;
        items.valid        <= 1'b0;
        items.op           <= tppt_pkg::OP_TICK;
        items.tick_time    <= '0;
        items.repeat_count <= '0;
        items.run_forever  <= 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corner cases on the reset phase lengths (both zero)
        // Disarmed timer: tick, stop and the unused code yield nothing
        send_item(tppt_pkg::OP_TICK,  32'h0000_0000, '0, 1'b0);
        send_item(tppt_pkg::OP_STOP,  32'h0000_0001, '0, 1'b0);
        send_item(OP_UNUSED,          32'hFFFF_FFFF, '1, 1'b1);
        // Zero repeat count: first tick disarms without an event
        send_item(tppt_pkg::OP_START, 32'h0000_0010, '0, 1'b0);
        send_item(tppt_pkg::OP_TICK,  32'h0000_0011, '0, 1'b0);
        send_item(tppt_pkg::OP_TICK,  32'h0000_0012, '0, 1'b0);
        // Repeat count of two with zero-length phases: low+high on the first tick
        send_item(tppt_pkg::OP_START, 32'h0000_0020, 16'd2, 1'b0);
        send_item(tppt_pkg::OP_TICK,  32'hFFFF_FFFF, '0, 1'b0);
        send_item(tppt_pkg::OP_TICK,  32'h8000_0000, '0, 1'b0);
        send_item(tppt_pkg::OP_TICK,  32'h7FFF_FFFF, '0, 1'b0);
        send_item(tppt_pkg::OP_TICK,  32'h0000_0024, '0, 1'b0);
        // Forever mode ignores a full count
        send_item(tppt_pkg::OP_START, 32'h0000_0030, '1, 1'b1);
        send_item(tppt_pkg::OP_TICK,  32'h0000_0031, '1, 1'b1);
        send_item(tppt_pkg::OP_TICK,  32'h0000_0032, '0, 1'b0);
        send_item(tppt_pkg::OP_TICK,  32'h0000_0033, '0, 1'b0);
        // Restart while armed, then stop and tick a stopped timer
        send_item(tppt_pkg::OP_START, 32'h0000_0040, 16'd1, 1'b0);
        send_item(tppt_pkg::OP_TICK,  32'h0000_0041, '0, 1'b0);
        send_item(tppt_pkg::OP_STOP,  32'h0000_0042, '0, 1'b0);
        send_item(tppt_pkg::OP_TICK,  32'h0000_0043, '0, 1'b0);
        send_item(tppt_pkg::OP_STOP,  32'h0000_0044, '0, 1'b0);

        // Random phases, each on a fresh phase-length setting
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            drain_events();
            case (phase)
                0:
                begin
                    first_len  = 16'd3;
                    second_len = 16'd2;
                end
                1:
                begin
                    first_len  = 16'd0;
                    second_len = 16'd0;
                end
                2:
                begin
                    first_len  = 16'hFFFF;
                    second_len = 16'hFFFF;
                end
                3:
                begin
                    first_len  = 16'd1;
                    second_len = 16'd0;
                end
                4:
                begin
                    first_len  = 16'd0;
                    second_len = 16'hFFFF;
                end
                default:
                begin
                    first_len  = PERIOD_BITS'($urandom_range(7));
                    second_len = PERIOD_BITS'($urandom_range(7));
                end
            endcase
            program_phases(first_len, second_len);

            // Both sides gap at first, then swapped rates, then none
            if (phase < 2)
            begin
                send_idle_pct = 36;
                recv_idle_pct = 54;
            end
            else if (phase < 4)
            begin
                send_idle_pct = 54;
                recv_idle_pct = 36;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            // Open each phase with a well-formed start
            send_item(tppt_pkg::OP_START, $urandom,
                      COUNT_BITS'($urandom_range(1, 12)), 1'b0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Stall the consumer while commands keep coming
                if (phase == 1 && n == 40)
                    stall_cycles_left = HOLD_OFF_CYCLES;
                // Pause the producer until all events are out
                if (phase == 3 && n == 80)
                    drain_events();
                send_random_item();
            end
        end

        drain_events();
        if (sb.mismatches == 0 && sb.expected_events.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
